FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define RPH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Expression must never be true at a rising edge outside reset.
`define RPH_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define RPH_ASSERT(lbl, clk, rst_n, prop)
`define RPH_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: hw/rtl/rph_pkg.sv
// Constants, codes and types of the RF phase histogrammer.
`timescale 1ns / 1ps
`default_nettype none
package rph_pkg;

    // Histogram geometry
    localparam int NUM_LABELS       = 221;
    localparam int FINE_FIRST_LABEL = 200;
    localparam int COARSE_BINS      = 500;
    localparam int FINE_BINS        = 2500;
    localparam int COUNT_W          = 32;

    localparam int COARSE_LABELS = (FINE_FIRST_LABEL < NUM_LABELS) ? FINE_FIRST_LABEL
                                                                   : NUM_LABELS;
    localparam int FINE_LABELS   = NUM_LABELS - COARSE_LABELS;
    localparam int COARSE_STRIDE = COARSE_BINS + 2;
    localparam int FINE_STRIDE   = FINE_BINS + 2;
    localparam int COARSE_DEPTH  = COARSE_LABELS * COARSE_STRIDE;
    localparam int FINE_DEPTH    = FINE_LABELS * FINE_STRIDE;
    localparam int MAX_DEPTH     = (COARSE_DEPTH > FINE_DEPTH) ? COARSE_DEPTH : FINE_DEPTH;
    localparam int COARSE_AW     = $clog2(COARSE_DEPTH);
    localparam int FINE_AW       = $clog2(FINE_DEPTH);
    localparam int ADDR_W        = $clog2(MAX_DEPTH);

    // Field widths
    localparam int LABEL_W    = 8;
    localparam int TIME_W     = 48;
    localparam int PERIOD_W   = 24;
    localparam int BIN_W      = 12;
    localparam int SHIFT_W    = 20;
    localparam int PHASE_W    = 25;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // Histogram window in ps
    localparam int HIST_LOW_PS  = 100000;
    localparam int HIST_SPAN_PS = 500000;

    // Reset values
    localparam int RF_PERIOD_RESET = 399998;
    localparam int RF_SHIFT_RESET  = 50000;
    localparam int RF_LABEL_RESET  = 251;

    // Serial divider and bin arithmetic widths
    localparam int DIV_W    = TIME_W + 1;
    localparam int STEP_W   = $clog2(DIV_W);
    localparam int OFFSET_W = PHASE_W + 1;
    localparam int OFS_UW   = $clog2(HIST_SPAN_PS);
    localparam int MAXBINS  = (FINE_BINS > COARSE_BINS) ? FINE_BINS : COARSE_BINS;
    localparam int NBINS_W  = $clog2(MAXBINS + 1);
    localparam int PROD_W   = OFS_UW + NBINS_W;
    localparam int STRIDE_W = $clog2(MAXBINS + 3);
    localparam int AP_W     = LABEL_W + STRIDE_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RF_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RF_LABEL = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_FILLED      = 3'd0,
        ST_RF          = 3'd1,
        ST_IGNORED     = 3'd2,
        ST_NEGATIVE    = 3'd3,
        ST_ZERO_PERIOD = 3'd4,
        ST_READ        = 3'd5
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_DECODE  = 13'b0000000000100,
        S_CHECK   = 13'b0000000001000,
        S_DIV_MOD = 13'b0000000010000,
        S_PHASE   = 13'b0000000100000,
        S_OFFSET  = 13'b0000001000000,
        S_BIN     = 13'b0000010000000,
        S_DIV_BIN = 13'b0000100000000,
        S_BIN_SET = 13'b0001000000000,
        S_ADDR    = 13'b0010000000000,
        S_READ    = 13'b0100000000000,
        S_UPDATE  = 13'b1000000000000
    } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rf_phase_histogrammer.sv
// Top level of the RF phase histogrammer: sequencer, bit-serial divider, histogram RAMs.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One beat at a time: a beat is taken when start is high and busy is low, and
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. After reset the block sweeps both histogram RAMs to zero,
// one entry a cycle, and stays busy until it has swept MAX_DEPTH (100400)
// addresses; configuration writes are taken during the sweep as ever. A hit that
// fills a regular bin passes through the phase modulo and then the bin scaling,
// which each run through one shared restoring divider
// that retires one quotient bit a cycle over DIV_W (49) steps. A fill into the
// underflow or overflow bin skips the second pass. RF hits, ignored labels,
// negative or zero-period hits finish without the divider, and a histogram read
// goes through S_ADDR, S_READ and S_UPDATE (histogram RAM read then registered
// data), or finishes at decode for a bin past the overflow bin.
// Bin counts saturate at all ones.
module rf_phase_histogrammer
    import rph_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       operation,
    input  logic [LABEL_W-1:0]         label,
    input  logic [TIME_W-1:0]          time_ps,
    input  logic [PERIOD_W-1:0]        rf_period_ps,
    input  logic [BIN_W-1:0]           read_bin,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic                       out_of_order,
    output logic signed [PHASE_W-1:0]  phase_ps,
    output logic [BIN_W-1:0]           bin_index,
    output logic [COUNT_W-1:0]         bin_count
);

    // Control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [LABEL_W-1:0]  rf_label_reg;
    logic [TIME_W-1:0]   rf_ref_reg, rf_ref_next;
    logic [PERIOD_W-1:0] rf_period_reg, rf_period_next;
    logic [TIME_W-1:0]   last_fill_reg, last_fill_next;
    logic                done_reg, done_next;

    // Captured beat
    logic                op_reg, op_next;
    logic [LABEL_W-1:0]  label_reg, label_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [BIN_W-1:0]    rbin_reg, rbin_next;

    // Datapath
    logic [DIV_W-1:0]          sum_reg, sum_next;
    logic [DIV_W-1:0]          dq_reg, dq_next;
    logic [PERIOD_W-1:0]       rem_reg, rem_next;
    logic [PERIOD_W-1:0]       dvs_reg, dvs_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [PHASE_W-1:0] phase_reg, phase_next;
    logic [OFFSET_W-1:0]       offset_reg, offset_next;
    logic [BIN_W-1:0]          bin_reg, bin_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic                      ooo_reg, ooo_next;

    // Result
    status_t                   res_status_reg, res_status_next;
    logic                      res_ooo_reg, res_ooo_next;
    logic signed [PHASE_W-1:0] res_phase_reg, res_phase_next;
    logic [BIN_W-1:0]          res_bin_reg, res_bin_next;
    logic [COUNT_W-1:0]        res_count_reg, res_count_next;

    // Helpers
    logic                      fine;
    logic [BIN_W-1:0]          last_bin;
    logic [NBINS_W-1:0]        nbins;
    logic [PERIOD_W:0]         trial;
    logic [PERIOD_W:0]         trial_diff;
    logic                      trial_ge;
    logic [PERIOD_W-1:0]       rem_step;
    logic [DIV_W-1:0]          dq_step;
    logic [LABEL_W-1:0]        lab_off;
    logic [STRIDE_W-1:0]       stride;
    logic [AP_W-1:0]           addr_prod;
    logic [COUNT_W-1:0]        rdata_c, rdata_f, old_count, new_count;
    logic                      fill_we, clearing;
    logic                      we_c, we_f;
    logic [ADDR_W-1:0]         waddr;
    logic [COUNT_W-1:0]        wdata;
    logic                      fin;
    status_t                   fin_status;
    logic [COUNT_W-1:0]        fin_count;
    logic [BIN_W-1:0]          fin_bin;
    logic signed [PHASE_W-1:0] fin_phase;

    // Histogram geometry of the captured label
    assign fine     = (label_reg >= LABEL_W'(COARSE_LABELS));
    assign last_bin = fine ? BIN_W'(FINE_BINS + 1) : BIN_W'(COARSE_BINS + 1);
    assign nbins    = fine ? NBINS_W'(FINE_BINS) : NBINS_W'(COARSE_BINS);

    // One restoring divider step: one quotient bit per cycle
    assign trial      = {rem_reg, dq_reg[DIV_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign trial_ge   = (trial >= {1'b0, dvs_reg});
    assign rem_step   = trial_ge ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    assign dq_step    = {dq_reg[DIV_W-2:0], trial_ge};

    // Histogram entry address
    assign lab_off   = fine ? (label_reg - LABEL_W'(COARSE_LABELS)) : label_reg;
    assign stride    = fine ? STRIDE_W'(FINE_STRIDE) : STRIDE_W'(COARSE_STRIDE);
    assign addr_prod = AP_W'(lab_off) * AP_W'(stride);

    // Saturating count update
    assign old_count = fine ? rdata_f : rdata_c;
    assign new_count = (old_count == {COUNT_W{1'b1}}) ? old_count : old_count + 1'b1;

    // RAM write control: clearing sweep or fill
    assign clearing = (state_reg == S_CLEAR);
    assign fill_we  = (state_reg == S_UPDATE) && !op_reg;
    assign we_c     = clearing || (fill_we && !fine);
    assign we_f     = (clearing && (clr_reg < ADDR_W'(FINE_DEPTH))) || (fill_we && fine);
    assign waddr    = clearing ? clr_reg : addr_reg;
    assign wdata    = clearing ? '0 : new_count;

    rph_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (COARSE_DEPTH)
    ) u_coarse_ram (
        .clk   (clk),
        .we    (we_c),
        .waddr (waddr[COARSE_AW-1:0]),
        .wdata (wdata),
        .raddr (addr_reg[COARSE_AW-1:0]),
        .rdata (rdata_c)
    );

    rph_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (FINE_DEPTH)
    ) u_fine_ram (
        .clk   (clk),
        .we    (we_f),
        .waddr (waddr[FINE_AW-1:0]),
        .wdata (wdata),
        .raddr (addr_reg[FINE_AW-1:0]),
        .rdata (rdata_f)
    );

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rf_ref_next    = rf_ref_reg;
        rf_period_next = rf_period_reg;
        last_fill_next = last_fill_reg;
        op_next        = op_reg;
        label_next     = label_reg;
        time_next      = time_reg;
        period_next    = period_reg;
        rbin_next      = rbin_reg;
        sum_next       = sum_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        bin_next       = bin_reg;
        addr_next      = addr_reg;
        ooo_next       = ooo_reg;
        fin            = 1'b0;
        fin_status     = ST_FILLED;
        fin_count      = '0;
        fin_bin        = '0;
        fin_phase      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MAX_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = operation;
                    label_next  = label;
                    time_next   = time_ps;
                    period_next = rf_period_ps;
                    rbin_next   = read_bin;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (op_reg)
                begin
                    // histogram read
                    ooo_next = 1'b0;
                    fin_bin  = rbin_reg;
                    if (label_reg >= LABEL_W'(NUM_LABELS))
                    begin
                        fin        = 1'b1;
                        fin_status = ST_IGNORED;
                    end
                    else if (rbin_reg > last_bin)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_READ;
                    end
                    else
                    begin
                        bin_next   = rbin_reg;
                        state_next = S_ADDR;
                    end
                end
                else
                begin
                    // hit: RF label wins over histogram labels
                    ooo_next = (time_reg < last_fill_reg);
                    if (label_reg == rf_label_reg)
                    begin
                        rf_ref_next    = time_reg;
                        rf_period_next = period_reg;
                        fin            = 1'b1;
                        fin_status     = ST_RF;
                    end
                    else if (label_reg >= LABEL_W'(NUM_LABELS))
                    begin
                        fin        = 1'b1;
                        fin_status = ST_IGNORED;
                    end
                    else
                    begin
                        sum_next   = {1'b0, time_reg} + DIV_W'(shift_reg);
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sum_reg < {1'b0, rf_ref_reg})
                begin
                    fin        = 1'b1;
                    fin_status = ST_NEGATIVE;
                end
                else if (rf_period_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_status = ST_ZERO_PERIOD;
                end
                else
                begin
                    dq_next    = sum_reg - {1'b0, rf_ref_reg};
                    rem_next   = '0;
                    dvs_next   = rf_period_reg;
                    step_next  = '0;
                    state_next = S_DIV_MOD;
                end
            end
            S_DIV_MOD:
            begin
                dq_next   = dq_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                phase_next = $signed({1'b0, rem_reg})
                           - $signed({{(PHASE_W - SHIFT_W){1'b0}}, shift_reg});
                state_next = S_OFFSET;
            end
            S_OFFSET:
            begin
                offset_next = {phase_reg[PHASE_W-1], phase_reg} + OFFSET_W'(HIST_LOW_PS);
                state_next  = S_BIN;
            end
            S_BIN:
            begin
                if (offset_reg[OFFSET_W-1])
                begin
                    bin_next   = '0;
                    state_next = S_ADDR;
                end
                else if (offset_reg >= OFFSET_W'(HIST_SPAN_PS))
                begin
                    bin_next   = last_bin;
                    state_next = S_ADDR;
                end
                else
                begin
                    // offset * N, then divide by the span
                    dq_next    = DIV_W'(PROD_W'(offset_reg[OFS_UW-1:0]) * PROD_W'(nbins));
                    rem_next   = '0;
                    dvs_next   = PERIOD_W'(HIST_SPAN_PS);
                    step_next  = '0;
                    state_next = S_DIV_BIN;
                end
            end
            S_DIV_BIN:
            begin
                dq_next   = dq_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = S_BIN_SET;
                end
            end
            S_BIN_SET:
            begin
                bin_next   = dq_reg[BIN_W-1:0] + BIN_W'(1);
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                addr_next  = ADDR_W'(addr_prod) + ADDR_W'(bin_reg);
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                fin     = 1'b1;
                fin_bin = bin_reg;
                if (op_reg)
                begin
                    fin_status = ST_READ;
                    fin_count  = old_count;
                end
                else
                begin
                    fin_status     = ST_FILLED;
                    fin_count      = new_count;
                    fin_phase      = phase_reg;
                    last_fill_next = time_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    // Result beat
    assign done_next       = fin;
    assign res_status_next = fin ? fin_status : res_status_reg;
    assign res_ooo_next    = fin ? ooo_next : res_ooo_reg;
    assign res_phase_next  = fin ? fin_phase : res_phase_reg;
    assign res_bin_next    = fin ? fin_bin : res_bin_reg;
    assign res_count_next  = fin ? fin_count : res_count_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            shift_reg     <= SHIFT_W'(RF_SHIFT_RESET);
            rf_label_reg  <= LABEL_W'(RF_LABEL_RESET);
            rf_ref_reg    <= '0;
            rf_period_reg <= PERIOD_W'(RF_PERIOD_RESET);
            last_fill_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rf_ref_reg    <= rf_ref_next;
            rf_period_reg <= rf_period_next;
            last_fill_reg <= last_fill_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RF_SHIFT: shift_reg    <= cfg_data[SHIFT_W-1:0];
                    CFG_RF_LABEL: rf_label_reg <= cfg_data[LABEL_W-1:0];
                    default:      shift_reg    <= shift_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        label_reg      <= label_next;
        time_reg       <= time_next;
        period_reg     <= period_next;
        rbin_reg       <= rbin_next;
        sum_reg        <= sum_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        step_reg       <= step_next;
        phase_reg      <= phase_next;
        offset_reg     <= offset_next;
        bin_reg        <= bin_next;
        addr_reg       <= addr_next;
        ooo_reg        <= ooo_next;
        res_status_reg <= res_status_next;
        res_ooo_reg    <= res_ooo_next;
        res_phase_reg  <= res_phase_next;
        res_bin_reg    <= res_bin_next;
        res_count_reg  <= res_count_next;
    end

    // Ports
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = res_status_reg;
    assign out_of_order = res_ooo_reg;
    assign phase_ps     = res_phase_reg;
    assign bin_index    = res_bin_reg;
    assign bin_count    = res_count_reg;

    // Checks
    `RPH_ASSERT(a_done_single, clk, rst_n, done |=> !done)
    `RPH_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    `RPH_ASSERT(a_fill_nonzero, clk, rst_n, (done && status == ST_FILLED) |-> (bin_count != '0))
    `RPH_ASSERT_NEVER(a_no_done_clear, clk, rst_n, done && (state_reg == S_CLEAR))

endmodule
`default_nettype wire

FILE: hw/rtl/rph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
